@@ rtl/core/aid_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ARM instruction decoder: class, sub-operation and shift codes,
// mode flag positions and the decoded result record. No dependencies.

package aid_pkg;

	localparam logic [2:0] CLS_COPROC = 3'd0;
	localparam logic [2:0] CLS_BRANCH = 3'd1;
	localparam logic [2:0] CLS_LDST   = 3'd2;
	localparam logic [2:0] CLS_BLOCK  = 3'd3;
	localparam logic [2:0] CLS_MUL    = 3'd4;
	localparam logic [2:0] CLS_ALU    = 3'd5;

	localparam logic [3:0] CP_CDP = 4'd0;
	localparam logic [3:0] CP_MCR = 4'd1;
	localparam logic [3:0] CP_MRC = 4'd2;

	localparam logic [3:0] MUL_MUL = 4'd0;
	localparam logic [3:0] MUL_MLA = 4'd1;

	localparam logic [3:0] ALU_MOV = 4'd13;
	localparam logic [3:0] ALU_MVN = 4'd15;

	localparam logic [2:0] SHK_PLAIN = 3'd0;
	localparam logic [2:0] SHK_LSL   = 3'd1;
	localparam logic [2:0] SHK_LSR   = 3'd2;
	localparam logic [2:0] SHK_ASR   = 3'd3;
	localparam logic [2:0] SHK_ROR   = 3'd4;
	localparam logic [2:0] SHK_RRX   = 3'd5;

	localparam int FLG_S    = 0;
	localparam int FLG_LINK = 1;
	localparam int FLG_LOAD = 2;
	localparam int FLG_BYTE = 3;
	localparam int FLG_PRE  = 4;
	localparam int FLG_UP   = 5;
	localparam int FLG_WB   = 6;
	localparam int FLG_PSR  = 7;
	localparam int FLG_IMM  = 8;
	localparam int FLG_SREG = 9;

	typedef struct packed {
		logic        recognized;
		logic [2:0]  instr_class;
		logic [3:0]  cond_code;
		logic [3:0]  sub_op;
		logic [9:0]  mode_flags;
		logic [3:0]  reg_dest;
		logic [3:0]  reg_base;
		logic [3:0]  reg_operand;
		logic [3:0]  reg_shift;
		logic [31:0] operand_value;
		logic [2:0]  shift_kind;
		logic [4:0]  shift_amount;
	} dec_t;

endpackage

@@ rtl/core/arm_instruction_decoder_unit.sv @@
`timescale 1ns / 1ps
// Top level of the ARM instruction decoder: input register, decode logic and result register.
// Depends on aid_pkg for codes and the decoded result record.
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  instr_address, instr_word
// out      source     out_valid/out_ready  recognized ... shift_amount
//
// Each beat passes through two registers: it is captured on input and its decoded
// result is then registered, giving a throughput of one beat per cycle while the
// output is not stalled. A stall on the output holds both stages; the input stage
// still takes a beat whenever it is empty or moving. Reset clears both stages at once,
// without a clock edge, and a beat can be taken as soon as reset is released.

module arm_instruction_decoder_unit
	import aid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr_address,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        recognized,
	output logic [2:0]  instr_class,
	output logic [3:0]  cond_code,
	output logic [3:0]  sub_op,
	output logic [9:0]  mode_flags,
	output logic [3:0]  reg_dest,
	output logic [3:0]  reg_base,
	output logic [3:0]  reg_operand,
	output logic [3:0]  reg_shift,
	output logic [31:0] operand_value,
	output logic [2:0]  shift_kind,
	output logic [4:0]  shift_amount
);

	logic        vld_s1;
	logic        vld_s2;
	logic [31:0] addr_s1;
	logic [31:0] word_s1;
	dec_t        res_s2;
	dec_t        dec;
	logic        adv_s1;

	assign adv_s1   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addr_s1 <= instr_address;
			word_s1 <= instr_word;
		end
		if (adv_s1 && vld_s1) begin
			res_s2 <= dec;
		end
	end

	logic [31:0] w;
	logic [23:0] boff;
	logic [63:0] rot_wide;
	logic [4:0]  rot_amt;
	logic [2:0]  ishk;
	logic [4:0]  isha;
	logic [3:0]  op;
	logic        cmp_op;
	logic        alu_bad;

	assign w        = word_s1;
	assign boff     = w[23:0];
	assign rot_amt  = {w[11:8], 1'b0};
	assign rot_wide = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot_amt;
	assign op       = w[24:21];
	assign cmp_op   = (op[3:2] == 2'b10);
	assign alu_bad  = (!w[25] && w[4] && w[7]) || (cmp_op && !w[20]);

	// Immediate shift: lsl #0 means no shift, ror #0 means rrx.
	always_comb begin
		if (w[11:7] == 5'd0 && w[6:5] == 2'd0) begin
			ishk = SHK_PLAIN;
		end else if (w[11:7] == 5'd0 && w[6:5] == 2'd3) begin
			ishk = SHK_RRX;
		end else begin
			ishk = {1'b0, w[6:5]} + 3'd1;
		end
		isha = w[11:7];
	end

	always_comb begin
		dec = '0;
		if (w[27:24] == 4'he) begin
			dec.recognized  = 1'b1;
			dec.instr_class = CLS_COPROC;
			dec.reg_dest    = w[15:12];
			dec.reg_base    = w[19:16];
			dec.reg_operand = w[3:0];
			if (w[4]) begin
				dec.sub_op        = w[20] ? CP_MRC : CP_MCR;
				dec.operand_value = {21'd0, w[7:5], 1'b0, w[23:21], w[11:8]};
			end else begin
				dec.sub_op        = CP_CDP;
				dec.operand_value = {21'd0, w[7:5], w[23:20], w[11:8]};
			end
		end else if (w[27:25] == 3'b101) begin
			dec.recognized          = 1'b1;
			dec.instr_class         = CLS_BRANCH;
			dec.mode_flags[FLG_LINK] = w[24];
			dec.operand_value = addr_s1 + 32'd8 + {{6{boff[23]}}, boff, 2'b00};
		end else if (w[27:26] == 2'b01) begin
			if (!(w[25] && w[4])) begin
				dec.recognized           = 1'b1;
				dec.instr_class          = CLS_LDST;
				dec.mode_flags[FLG_LOAD] = w[20];
				dec.mode_flags[FLG_BYTE] = w[22];
				dec.mode_flags[FLG_PRE]  = w[24];
				dec.mode_flags[FLG_UP]   = w[23];
				dec.mode_flags[FLG_WB]   = w[21];
				dec.reg_dest             = w[15:12];
				dec.reg_base             = w[19:16];
				if (w[25]) begin
					dec.reg_operand  = w[3:0];
					dec.shift_kind   = ishk;
					dec.shift_amount = isha;
				end else begin
					dec.mode_flags[FLG_IMM] = 1'b1;
					dec.operand_value       = {20'd0, w[11:0]};
				end
			end
		end else if (w[27:25] == 3'b100) begin
			dec.recognized           = 1'b1;
			dec.instr_class          = CLS_BLOCK;
			dec.mode_flags[FLG_LOAD] = w[20];
			dec.mode_flags[FLG_PRE]  = w[24];
			dec.mode_flags[FLG_UP]   = w[23];
			dec.mode_flags[FLG_PSR]  = w[22];
			dec.mode_flags[FLG_WB]   = w[21];
			dec.reg_base             = w[19:16];
			dec.operand_value        = {16'd0, w[15:0]};
		end else if (w[27:22] == 6'd0 && w[7:4] == 4'b1001) begin
			dec.recognized        = 1'b1;
			dec.instr_class       = CLS_MUL;
			dec.sub_op            = w[21] ? MUL_MLA : MUL_MUL;
			dec.mode_flags[FLG_S] = w[20];
			dec.reg_dest          = w[19:16];
			dec.reg_base          = w[21] ? w[15:12] : 4'd0;
			dec.reg_operand       = w[3:0];
			dec.reg_shift         = w[11:8];
		end else if (w[27:26] == 2'b00) begin
			if (!alu_bad) begin
				dec.recognized        = 1'b1;
				dec.instr_class       = CLS_ALU;
				dec.sub_op            = op;
				dec.mode_flags[FLG_S] = w[20];
				dec.reg_dest          = w[15:12];
				dec.reg_base          = (op == ALU_MOV || op == ALU_MVN) ? 4'd0 : w[19:16];
				if (w[25]) begin
					dec.mode_flags[FLG_IMM] = 1'b1;
					dec.operand_value       = rot_wide[31:0];
				end else if (w[4]) begin
					dec.mode_flags[FLG_SREG] = 1'b1;
					dec.reg_operand          = w[3:0];
					dec.reg_shift            = w[11:8];
					dec.shift_kind           = {1'b0, w[6:5]} + 3'd1;
				end else begin
					dec.reg_operand  = w[3:0];
					dec.shift_kind   = ishk;
					dec.shift_amount = isha;
				end
			end
		end
		dec.cond_code = dec.recognized ? w[31:28] : 4'd0;
	end

	assign out_valid     = vld_s2;
	assign recognized    = res_s2.recognized;
	assign instr_class   = res_s2.instr_class;
	assign cond_code     = res_s2.cond_code;
	assign sub_op        = res_s2.sub_op;
	assign mode_flags    = res_s2.mode_flags;
	assign reg_dest      = res_s2.reg_dest;
	assign reg_base      = res_s2.reg_base;
	assign reg_operand   = res_s2.reg_operand;
	assign reg_shift     = res_s2.reg_shift;
	assign operand_value = res_s2.operand_value;
	assign shift_kind    = res_s2.shift_kind;
	assign shift_amount  = res_s2.shift_amount;

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("Input stage empty but not ready.");

	a_unrec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !recognized) |->
		(instr_class == 3'd0 && mode_flags == 10'd0 && operand_value == 32'd0 &&
		 cond_code == 4'd0 && shift_kind == 3'd0))
		else $error("Unrecognised beat carries non-zero fields.");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (instr_class <= CLS_ALU && shift_kind <= SHK_RRX))
		else $error("Class or shift kind code out of range.");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s1) |=> vld_s2)
		else $error("Beat lost between stages.");

	a_coproc_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && recognized && instr_class == CLS_COPROC) |-> mode_flags == 10'd0)
		else $error("Coprocessor beat with mode flags set.");

endmodule
